// ----- hw/rtl/smcc_pkg.sv -----
// Shared types and constants for the sensor matrix crosstalk compensation core.
// Depends on nothing; imported by sensor_matrix_crosstalk_comp_core.
package smcc_pkg;

  localparam int SAMPLE_W = 12;
  localparam int ROWF_W   = 5;
  localparam int COLF_W   = 5;
  localparam int VALUE_W  = 16;
  localparam int NUM_W    = 2 * SAMPLE_W;   // width of gain * sample
  localparam int CNT_W    = $clog2(NUM_W);
  localparam int IN_W     = ROWF_W + COLF_W + SAMPLE_W;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 2;

  typedef logic [SAMPLE_W-1:0] sample_t;

  localparam logic [VALUE_W-1:0]  SAT_VALUE  = 16'd65534;
  localparam logic [SAMPLE_W-1:0] MODE1_GAIN = 12'd255;
  localparam logic [SAMPLE_W-1:0] FS_RESET   = 12'd4095;

  // Opcodes carried in s_tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd2;

endpackage

// ----- hw/rtl/sensor_matrix_crosstalk_comp_core.sv -----
// Crosstalk compensation core for a resistive pressure matrix: cell store,
// column sums and a bit-serial divider. Depends on smcc_pkg.
//
// Usage: each input word on the s_ group is a cell write (s_tuser = 0) or a
// compensated read (s_tuser = 1). A write stores the thresholded sample and
// updates its column sum; it yields no output word. A read yields one word
// on the m_ group: the compensated value in m_tdata, the saturation flag in
// m_tuser. Registers are to be set through the cfg_ channel while the core is
// idle; the core itself does not enforce this. A write passes through the
// lookup state and is then done. A read that needs a division passes through
// lookup, the restoring divider (one quotient bit per cycle) and the output
// state, then takes the next word. A read that needs none goes from lookup
// straight to the output state.
// One item is in work at a time; s_tready is high only when the core is free.
// After rst the core sweeps the cell store and the column sums to zero,
// one entry a cycle through all ROWS*COLS cells; s_tready stays low meanwhile.
// If the receiver stalls, the result sits in the output register and the
// core still takes the next item; it waits only when a second result is
// ready before the first has been taken.
module sensor_matrix_crosstalk_comp_core #(
  parameter int ROWS = 24,
  parameter int COLS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // s_tdata from bit 0: row[4:0], col[9:5], raw[21:10], zero fill
  input  logic [smcc_pkg::IN_TDATA_W-1:0]    s_tdata,
  // s_tuser: opcode
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // m_tdata from bit 0: value[15:0]
  output logic [smcc_pkg::VALUE_W-1:0]       m_tdata,
  // m_tuser: saturated
  output logic                               m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smcc_pkg::SAMPLE_W-1:0]      cfg_data
);
  import smcc_pkg::*;

  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLS);
  localparam int SUM_W  = $clog2(ROWS * 4095 + 1);
  localparam int DEN_W  = SUM_W + 2;
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_DIV, ST_FIN} state_t;

  state_t state;

  // Configuration registers.
  sample_t threshold;
  logic    gain_mode;
  sample_t full_scale;

  // Captured item.
  logic              op;
  logic              in_range;
  logic [ADDR_W-1:0] addr;
  logic [COL_W-1:0]  col_addr;
  sample_t           raw;

  logic [ADDR_W-1:0] clr_addr;

  // Memories and their registered read data.
  sample_t           cell_mem [CELLS];
  logic [SUM_W-1:0]  sum_mem  [COLS];
  sample_t           cell_rd;
  logic [SUM_W-1:0]  sum_rd;

  // Divider.
  logic [NUM_W-1:0]    quo;
  logic [SAMPLE_W-1:0] rem;
  sample_t             den;
  logic [CNT_W-1:0]    cnt;

  logic [VALUE_W-1:0] res_value;
  logic               res_sat;

  // Input field views.
  logic [ROWF_W-1:0] in_row;
  logic [COLF_W-1:0] in_col;
  sample_t           in_raw;
  logic              in_ok;
  logic [ADDR_W-1:0] in_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [COL_W-1:0]  rd_col;
  logic              accept;

  assign in_row = s_tdata[ROWF_W-1:0];
  assign in_col = s_tdata[ROWF_W+COLF_W-1:ROWF_W];
  assign in_raw = s_tdata[IN_W-1:ROWF_W+COLF_W];
  assign in_ok  = (int'(in_row) < ROWS) && (int'(in_col) < COLS);
  assign in_addr = ADDR_W'(in_row) * ADDR_W'(COLS) + ADDR_W'(in_col);
  assign rd_addr = in_ok ? in_addr : '0;
  assign rd_col  = in_ok ? COL_W'(in_col) : '0;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  // Lookup-stage arithmetic.
  sample_t           new_val;
  logic [SUM_W-1:0]  new_sum;
  logic [DEN_W-1:0]  den_full;
  logic              den_pos;
  logic              above;
  sample_t           gain;

  assign new_val  = (raw > threshold) ? raw : '0;
  assign new_sum  = sum_rd - SUM_W'(cell_rd) + SUM_W'(new_val);
  assign den_full = DEN_W'(full_scale) + DEN_W'(cell_rd) - DEN_W'(sum_rd);
  assign den_pos  = !den_full[DEN_W-1] && (den_full != '0);
  assign above    = cell_rd > threshold;
  assign gain     = gain_mode ? MODE1_GAIN : full_scale;

  // Memory write control: the clearing sweep or a cell write.
  logic              wr_item;
  logic              cell_we;
  logic              sum_we;
  logic [ADDR_W-1:0] cell_waddr;
  logic [COL_W-1:0]  sum_waddr;
  sample_t           cell_wdata;
  logic [SUM_W-1:0]  sum_wdata;

  assign wr_item    = (state == ST_LOOK) && (op == OP_WRITE) && in_range;
  assign cell_we    = (state == ST_CLEAR) || wr_item;
  assign sum_we     = ((state == ST_CLEAR) && (clr_addr < ADDR_W'(COLS))) || wr_item;
  assign cell_waddr = (state == ST_CLEAR) ? clr_addr : addr;
  assign sum_waddr  = (state == ST_CLEAR) ? COL_W'(clr_addr) : col_addr;
  assign cell_wdata = (state == ST_CLEAR) ? '0 : new_val;
  assign sum_wdata  = (state == ST_CLEAR) ? '0 : new_sum;

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rd <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rd <= sum_mem[rd_col];
  end

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  logic [SAMPLE_W:0]   rem_sh;
  logic                fits;
  logic [SAMPLE_W-1:0] rem_next;

  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign fits     = rem_sh >= {1'b0, den};
  assign rem_next = fits ? SAMPLE_W'(rem_sh - {1'b0, den}) : rem_sh[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= '0;
      gain_mode  <= 1'b0;
      full_scale <= FS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD:  threshold  <= cfg_data;
        REG_GAIN_MODE:  gain_mode  <= cfg_data[0];
        REG_FULL_SCALE: full_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // In ST_FIN the output register is reloaded below, so it is not cleared here.
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CELL_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op       <= s_tuser;
            in_range <= in_ok;
            addr     <= rd_addr;
            col_addr <= rd_col;
            raw      <= in_raw;
            state    <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (op == OP_WRITE) begin
            state <= ST_IDLE;
          end else if (!in_range || !above) begin
            res_value <= '0;
            res_sat   <= 1'b0;
            state     <= ST_FIN;
          end else if (!den_pos) begin
            res_value <= SAT_VALUE;
            res_sat   <= 1'b1;
            state     <= ST_FIN;
          end else begin
            quo   <= NUM_W'(gain) * NUM_W'(cell_rd);
            den   <= den_full[SAMPLE_W-1:0];
            rem   <= '0;
            cnt   <= CNT_W'(NUM_W - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          quo <= {quo[NUM_W-2:0], fits};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_FIN;
            if ({quo[NUM_W-2:0], fits} > NUM_W'(SAT_VALUE)) begin
              res_value <= SAT_VALUE;
              res_sat   <= 1'b1;
            end else begin
              res_value <= VALUE_W'({quo[NUM_W-2:0], fits});
              res_sat   <= 1'b0;
            end
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_value;
            m_tuser  <= res_sat;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/sensor_matrix_crosstalk_comp_core_tb.sv -----
// Self-checking testbench for sensor_matrix_crosstalk_comp_core: a short table of cell
// writes and reads, then random traffic under several register settings and idle patterns.
// Depends on smcc_pkg and the core; results are checked against a cell model or the table.
`timescale 1ns / 100ps

module sensor_matrix_crosstalk_comp_core_tb;
  import smcc_pkg::*;

  localparam int ROWS       = 24;
  localparam int COLS       = 24;
  localparam int SETTLE_CYC = 40;
  localparam int HOLD_LEN   = 300;
  localparam int WDOG_LIMIT = 3000;  // covers the store sweep after reset and the long hold

  localparam int PH_N   [4] = '{600, 600, 550, 150};
  localparam int PH_THR [4] = '{0, 200, 50, 0};
  localparam int PH_GM  [4] = '{0, 1, 0, 1};
  localparam int PH_FS  [4] = '{4095, 2048, 3000, 4095};
  localparam int PH_SRC [4] = '{10, 67, 0, 0};
  localparam int PH_DST [4] = '{67, 10, 0, 0};

  typedef struct packed {
    logic                op;
    logic [ROWF_W-1:0]   row;
    logic [COLF_W-1:0]   col;
    logic [SAMPLE_W-1:0] raw;
  } cell_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               sat;
  } comp_res_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    cell_op_t            w;
    logic                typed;
    comp_res_t           res;
    logic [SAMPLE_W-1:0] thr;
    logic                gm;
    logic [SAMPLE_W-1:0] fs;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [VALUE_W-1:0]     m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [SAMPLE_W-1:0]    cfg_data = '0;

  // Cell model state and register copies.
  logic [SAMPLE_W-1:0] cells [ROWS][COLS] = '{default: '0};
  int unsigned         col_sum [COLS] = '{default: 0};
  logic [SAMPLE_W-1:0] thr_r = '0;
  logic                gmode_r = 1'b0;
  logic [SAMPLE_W-1:0] fs_r = FS_RESET;

  comp_res_t           comp_q [$];
  logic [9:0]          hot_q [$];    // recently written {row, col}
  stim_row_t           dir_tab [$];
  int                  fail_cnt = 0;
  int                  src_idle = 0;
  int                  dst_stall = 0;
  int                  hold_reqs = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;
  int                  idle_cycles = 0;

  sensor_matrix_crosstalk_comp_core #(.ROWS(ROWS), .COLS(COLS)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one cell word to the model; returns 1 when the word yields a result.
  function automatic bit model_cell_op(input cell_op_t w, output comp_res_t res);
    int unsigned v;
    int unsigned gain;
    longint      den;
    longint      q;
    bit          hit;
    res = '0;
    hit = (w.row < ROWS) && (w.col < COLS);
    if (w.op == OP_WRITE) begin
      if (hit) begin
        v = (w.raw <= thr_r) ? 0 : int'(w.raw);
        col_sum[w.col] = col_sum[w.col] - int'(cells[w.row][w.col]) + v;
        cells[w.row][w.col] = SAMPLE_W'(v);
      end
      return 1'b0;
    end
    if (hit && cells[w.row][w.col] > thr_r) begin
      v = int'(cells[w.row][w.col]);
      den = longint'(fs_r) - (longint'(col_sum[w.col]) - longint'(v));
      if (den <= 0) begin
        res = '{SAT_VALUE, 1'b1};
      end else begin
        gain = gmode_r ? int'(MODE1_GAIN) : int'(fs_r);
        q = longint'(gain * v) / den;
        if (q > longint'(SAT_VALUE)) res = '{SAT_VALUE, 1'b1};
        else res = '{VALUE_W'(q), 1'b0};
      end
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t row_wr(input int r, input int c, input int raw);
    stim_row_t t;
    t = '0;
    t.kind = ROW_ITEM;
    t.w = '{OP_WRITE, ROWF_W'(r), COLF_W'(c), SAMPLE_W'(raw)};
    return t;
  endfunction

  function automatic stim_row_t row_rd(input int r, input int c);
    stim_row_t t;
    t = '0;
    t.kind = ROW_ITEM;
    t.w = '{OP_READ, ROWF_W'(r), COLF_W'(c), '0};
    return t;
  endfunction

  // Read whose result is known without running the model.
  function automatic stim_row_t row_rdx(input int r, input int c, input int val, input bit sat);
    stim_row_t t;
    t = row_rd(r, c);
    t.typed = 1'b1;
    t.res = '{VALUE_W'(val), sat};
    return t;
  endfunction

  function automatic stim_row_t row_cfg(input int thr, input bit gm, input int fs);
    stim_row_t t;
    t = '0;
    t.kind = ROW_CFG;
    t.thr = SAMPLE_W'(thr);
    t.gm = gm;
    t.fs = SAMPLE_W'(fs);
    return t;
  endfunction

  // Mostly in-range traffic; reads favor recently written cells so that
  // stored values and column sums come into play.
  function automatic cell_op_t rand_cell_op();
    cell_op_t w;
    int       sel;
    w.op  = ($urandom_range(99) < 45) ? OP_READ : OP_WRITE;
    w.row = ($urandom_range(99) < 5) ? ROWF_W'($urandom_range(31, ROWS)) :
                                       ROWF_W'($urandom_range(ROWS - 1));
    w.col = ($urandom_range(99) < 5) ? COLF_W'($urandom_range(31, COLS)) :
                                       COLF_W'($urandom_range(COLS - 1));
    sel = int'($urandom_range(99));
    if (sel < 55) w.raw = SAMPLE_W'($urandom_range(255));
    else if (sel < 80) w.raw = SAMPLE_W'($urandom_range(1023));
    else w.raw = SAMPLE_W'($urandom_range(4095));
    if (w.op == OP_READ && hot_q.size() != 0 && $urandom_range(99) < 60)
      {w.row, w.col} = hot_q[$urandom_range(hot_q.size() - 1)];
    if (w.op == OP_WRITE && w.row < ROWS && w.col < COLS) begin
      hot_q.push_back({w.row, w.col});
      if (hot_q.size() > 16) void'(hot_q.pop_front());
    end
    return w;
  endfunction

  task automatic send_word(input cell_op_t w, input bit typed, input comp_res_t typed_res);
    logic [IN_TDATA_W-1:0] word;
    comp_res_t             res;
    if ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    word = '0;
    word[IN_W-1:0] = {w.raw, w.col, w.row};
    s_tdata  <= word;
    s_tuser  <= w.op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (model_cell_op(w, res)) comp_q.push_back(typed ? typed_res : res);
  endtask

  // Stops input and waits until the core has finished all its work.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (comp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_set(input logic [SAMPLE_W-1:0] thr, input logic gm,
                         input logic [SAMPLE_W-1:0] fs);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [SAMPLE_W-1:0]  val [3];
    idx = '{REG_THRESHOLD, REG_GAIN_MODE, REG_FULL_SCALE};
    val = '{thr, {{(SAMPLE_W - 1){1'b0}}, gm}, fs};
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_THRESHOLD: thr_r = val[i];
        REG_GAIN_MODE: gmode_r = val[i][0];
        default: fs_r = val[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold when the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= dst_stall);
    end
  end

  always @(posedge clk) begin
    comp_res_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (comp_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: unexpected word value %0d sat %0b", $time, m_tdata, m_tuser);
      end else begin
        exp_res = comp_q.pop_front();
        if (m_tdata !== exp_res.value || m_tuser !== exp_res.sat) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: got value %0d sat %0b, expected value %0d sat %0b", $time,
                     m_tdata, m_tuser, exp_res.value, exp_res.sat);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_tab = {
      row_rdx(0, 0, 0, 1'b0),             // store is clear after reset
      row_rdx(23, 23, 0, 1'b0),
      row_rdx(31, 0, 0, 1'b0),            // out-of-range reads give zero
      row_rdx(0, 31, 0, 1'b0),
      row_wr(31, 31, 4095),               // out-of-range write is dropped
      row_rdx(31, 31, 0, 1'b0),
      row_wr(0, 0, 4095),
      row_rdx(0, 0, 4095, 1'b0),
      row_wr(1, 0, 4095),
      row_rdx(0, 0, SAT_VALUE, 1'b1),     // denominator exactly zero
      row_wr(2, 0, 4095),
      row_rdx(1, 0, SAT_VALUE, 1'b1),     // denominator negative
      row_wr(23, 23, 1),
      row_rdx(23, 23, 1, 1'b0),
      row_wr(5, 5, 2048),
      row_rd(5, 5),
      row_cfg(4095, 1'b0, 4095),
      row_wr(6, 6, 4095),                 // at threshold, stored as zero
      row_rdx(6, 6, 0, 1'b0),
      row_rdx(5, 5, 0, 1'b0),             // stored value now below threshold
      row_cfg(100, 1'b1, 1),
      row_wr(10, 10, 4095),
      row_rdx(10, 10, SAT_VALUE, 1'b1),   // quotient far above the clamp
      row_rdx(23, 23, 0, 1'b0),
      row_wr(11, 10, 101),
      row_rdx(11, 10, SAT_VALUE, 1'b1),
      row_wr(12, 10, 100),
      row_rdx(12, 10, 0, 1'b0),
      row_cfg(0, 1'b0, 0),
      row_rdx(10, 10, SAT_VALUE, 1'b1),   // zero full scale
      row_cfg(0, 1'b1, 4095),
      row_rd(5, 5)
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        settle();
        cfg_set(dir_tab[i].thr, dir_tab[i].gm, dir_tab[i].fs);
      end else begin
        send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    for (int p = 0; p < 4; p++) begin
      settle();
      cfg_set(SAMPLE_W'(PH_THR[p]), PH_GM[p] != 0, SAMPLE_W'(PH_FS[p]));
      src_idle = PH_SRC[p];
      dst_stall <= PH_DST[p];
      // Last phase: the receiver holds off while words keep coming.
      if (p == 3) hold_reqs <= hold_reqs + 1;
      repeat (PH_N[p]) send_word(rand_cell_op(), 1'b0, '0);
    end

    settle();
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
